### rtl/tx_tune_lease_watchdog_macros.svh
// Assertion macros used by the transmit-tune lease watchdog RTL.
`ifndef TX_TUNE_LEASE_WATCHDOG_MACROS_SVH
`define TX_TUNE_LEASE_WATCHDOG_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define TTLW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tx tune lease watchdog: same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define TTLW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tx tune lease watchdog: next-cycle check failed");

`endif

### rtl/ttlw_pkg.sv
// Package for the transmit-tune lease watchdog: codes, item types, reset values.
`default_nettype none

package ttlw_pkg;

    // Parameter defaults
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    // Register reset values
    localparam logic [31:0] LEASE_TIMEOUT_RST = 32'd1000;
    localparam logic [31:0] HARD_LIMIT_RST    = 32'd10000;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLED       = 2'd0;
    localparam logic [1:0] CFG_LEASE_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_HARD_LIMIT    = 2'd2;

    // Request codes
    localparam logic [2:0] REQ_START     = 3'd0;
    localparam logic [2:0] REQ_KEEPALIVE = 3'd1;
    localparam logic [2:0] REQ_STOP      = 3'd2;
    localparam logic [2:0] REQ_TICK      = 3'd3;
    localparam logic [2:0] REQ_RECONCILE = 3'd4;
    localparam logic [2:0] REQ_SHUTDOWN  = 3'd5;

    // Arbiter grant answers
    localparam logic [1:0] GRANT_OK   = 2'd0;
    localparam logic [1:0] GRANT_BUSY = 2'd1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DISABLED = 3'd1,
        ST_BUSY     = 3'd2,
        ST_INVALID  = 3'd3,
        ST_EXPIRED  = 3'd4,
        ST_HARDLIM  = 3'd5,
        ST_HWERR    = 3'd6
    } status_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
        logic [31:0] lease_token;
        logic [1:0]  grant_status;
        logic        arbiter_cleanup_failed;
        logic        release_ok;
        logic        owner_is_tune;
        logic        watchdog_caused;
    } ttlw_req_t;

    typedef struct packed {
        status_t     status;
        logic        request_issued;
        logic        release_issued;
        logic        session_active;
        logic [31:0] starts_count;
        logic [31:0] stops_count;
        logic [31:0] watchdog_stops_count;
        logic [31:0] rejected_count;
        logic [31:0] cleanup_failures_count;
    } ttlw_rsp_t;

endpackage

`default_nettype wire

### rtl/tx_tune_lease_watchdog.sv
// Top level of the transmit-tune lease watchdog session controller.
`default_nettype none

// Lease-guarded transmit-tune session controller. Each request item (start,
// keepalive, stop, tick, reconcile, shutdown) carries the time in ms, a lease
// token and the arbiter's answers; the block keeps one session, ends it on the
// hard limit or lease timeout (wrapping subtraction at TIME_WIDTH bits), and
// returns one result item per request with the status, the arbiter actions,
// the session flag and five wrapping event counters (COUNT_WIDTH bits, shown
// as 32 bits). Throughput is one item per clock unless the result side
// stalls; each item passes through the input register and then the result
// register, with all decisions made by the single pass of logic between
// them. The input side keeps taking items while a result waits, until both
// registers are full. Write configuration only while no item is in flight.
module tx_tune_lease_watchdog #(
    parameter int TIME_WIDTH  = ttlw_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = ttlw_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_idx,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire ttlw_pkg::ttlw_req_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output ttlw_pkg::ttlw_rsp_t     rsp
);
    import ttlw_pkg::*;

    // Comparison width: wide enough for a time value and a 32-bit limit
    localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
    // Counter view width: wide enough to cut a 32-bit field from
    localparam int VW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    // Configuration registers
    logic        enabled_reg;
    logic [31:0] lease_timeout_reg;
    logic [31:0] hard_limit_reg;

    // Pipeline registers
    logic      s1_valid_reg;
    ttlw_req_t s1_item_reg;
    logic      rsp_valid_reg;
    ttlw_rsp_t rsp_item_reg;

    // Session state
    logic                  active_reg,   active_next;
    logic [31:0]           lease_reg,    lease_next;
    logic [TIME_WIDTH-1:0] start_reg,    start_next;
    logic [TIME_WIDTH-1:0] renew_reg,    renew_next;

    // Event counters
    logic [COUNT_WIDTH-1:0] start_cnt_reg,   start_cnt_next;
    logic [COUNT_WIDTH-1:0] stop_cnt_reg,    stop_cnt_next;
    logic [COUNT_WIDTH-1:0] wd_cnt_reg,      wd_cnt_next;
    logic [COUNT_WIDTH-1:0] reject_cnt_reg,  reject_cnt_next;
    logic [COUNT_WIDTH-1:0] cleanup_cnt_reg, cleanup_cnt_next;

    // Handshake
    logic rsp_load;
    logic s1_fire;
    logic req_fire;

    // Decision logic
    logic [CW-1:0]         now_ext;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] el_start;
    logic [TIME_WIDTH-1:0] el_renew;
    status_t               wd_why;
    status_t               end_why;
    status_t               status_c;
    logic                  do_end;
    logic                  quiet_end;
    logic                  clear_sess;
    logic                  req_iss;
    logic                  rel_iss;
    logic                  inc_start, inc_stop, inc_wd, inc_rej, inc_clean;
    ttlw_rsp_t             rsp_next;

    // Widen a counter, then take its low 32 bits for the result field
    function automatic logic [31:0] cnt_view(input logic [COUNT_WIDTH-1:0] c);
        logic [VW-1:0] e;
        e = VW'(c);
        return e[31:0];
    endfunction

    // Result register frees when empty or when its item is taken
    assign rsp_load  = !rsp_valid_reg || rsp_ready;
    assign s1_fire   = s1_valid_reg && rsp_load;
    assign req_ready = !s1_valid_reg || rsp_load;
    assign req_fire  = req_valid && req_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_item_reg;

    // Bring the time into the watchdog's modulus
    assign now_ext  = CW'(s1_item_reg.now_ms);
    assign now_t    = now_ext[TIME_WIDTH-1:0];
    assign el_start = now_t - start_reg;
    assign el_renew = now_t - renew_reg;

    // Watchdog: hard limit wins over lease expiry
    always_comb
    begin
        if (CW'(el_start) >= CW'(hard_limit_reg)) begin
            wd_why = ST_HARDLIM;
        end else if (CW'(el_renew) >= CW'(lease_timeout_reg)) begin
            wd_why = ST_EXPIRED;
        end else begin
            wd_why = ST_OK;
        end
    end

    // Request decode and session update, one item per pass
    always_comb
    begin
        status_c   = ST_OK;
        req_iss    = 1'b0;
        rel_iss    = 1'b0;
        do_end     = 1'b0;
        quiet_end  = 1'b0;
        end_why    = ST_OK;
        clear_sess = 1'b0;
        inc_start  = 1'b0;
        inc_stop   = 1'b0;
        inc_wd     = 1'b0;
        inc_rej    = 1'b0;
        inc_clean  = 1'b0;
        active_next = active_reg;
        lease_next  = lease_reg;
        start_next  = start_reg;
        renew_next  = renew_reg;

        unique case (s1_item_reg.req_type) inside
            REQ_START:
            begin
                if (!enabled_reg) begin
                    status_c = ST_DISABLED;
                end else if (active_reg) begin
                    inc_rej  = 1'b1;
                    status_c = ST_BUSY;
                end else if (s1_item_reg.lease_token == '0) begin
                    status_c = ST_INVALID;
                end else begin
                    req_iss = 1'b1;
                    if (s1_item_reg.grant_status != GRANT_OK) begin
                        inc_clean = s1_item_reg.arbiter_cleanup_failed;
                        status_c  = (s1_item_reg.grant_status == GRANT_BUSY) ?
                                    ST_BUSY : ST_HWERR;
                    end else begin
                        active_next = 1'b1;
                        lease_next  = s1_item_reg.lease_token;
                        start_next  = now_t;
                        renew_next  = now_t;
                        inc_start   = 1'b1;
                    end
                end
            end
            REQ_KEEPALIVE, REQ_STOP:
            begin
                if (!enabled_reg) begin
                    status_c = ST_DISABLED;
                end else if (!active_reg || s1_item_reg.lease_token == '0 ||
                             s1_item_reg.lease_token != lease_reg) begin
                    inc_rej  = 1'b1;
                    status_c = ST_INVALID;
                end else if (s1_item_reg.req_type == REQ_STOP) begin
                    do_end = 1'b1;
                end else if (wd_why != ST_OK) begin
                    do_end  = 1'b1;
                    end_why = wd_why;
                end else begin
                    renew_next = now_t;
                end
            end
            REQ_TICK:
            begin
                if (!enabled_reg) begin
                    status_c = ST_DISABLED;
                end else if (active_reg && wd_why != ST_OK) begin
                    do_end  = 1'b1;
                    end_why = wd_why;
                end
            end
            REQ_RECONCILE:
            begin
                if (active_reg && !s1_item_reg.owner_is_tune) begin
                    clear_sess = 1'b1;
                    inc_stop   = 1'b1;
                    inc_wd     = s1_item_reg.watchdog_caused;
                end
            end
            REQ_SHUTDOWN:
            begin
                if (active_reg) begin
                    do_end    = 1'b1;
                    quiet_end = 1'b1;
                end
            end
            default:
            begin
                // Unused codes: leave everything as it is
            end
        endcase

        // Ending a session releases ownership through the arbiter
        if (do_end) begin
            rel_iss    = 1'b1;
            clear_sess = 1'b1;
            inc_stop   = 1'b1;
            inc_wd     = (end_why == ST_EXPIRED) || (end_why == ST_HARDLIM);
            inc_clean  = !s1_item_reg.release_ok;
            if (!quiet_end) begin
                status_c = s1_item_reg.release_ok ? end_why : ST_HWERR;
            end
        end

        if (clear_sess) begin
            active_next = 1'b0;
            lease_next  = '0;
            start_next  = '0;
            renew_next  = '0;
        end
    end

    assign start_cnt_next   = start_cnt_reg   + COUNT_WIDTH'(inc_start);
    assign stop_cnt_next    = stop_cnt_reg    + COUNT_WIDTH'(inc_stop);
    assign wd_cnt_next      = wd_cnt_reg      + COUNT_WIDTH'(inc_wd);
    assign reject_cnt_next  = reject_cnt_reg  + COUNT_WIDTH'(inc_rej);
    assign cleanup_cnt_next = cleanup_cnt_reg + COUNT_WIDTH'(inc_clean);

    // Assemble the result from the values after this item
    always_comb
    begin
        rsp_next.status                 = status_c;
        rsp_next.request_issued         = req_iss;
        rsp_next.release_issued         = rel_iss;
        rsp_next.session_active         = active_next;
        rsp_next.starts_count           = cnt_view(start_cnt_next);
        rsp_next.stops_count            = cnt_view(stop_cnt_next);
        rsp_next.watchdog_stops_count   = cnt_view(wd_cnt_next);
        rsp_next.rejected_count         = cnt_view(reject_cnt_next);
        rsp_next.cleanup_failures_count = cnt_view(cleanup_cnt_next);
    end

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enabled_reg       <= 1'b0;
            lease_timeout_reg <= LEASE_TIMEOUT_RST;
            hard_limit_reg    <= HARD_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_ENABLED:       enabled_reg       <= cfg_wdata[0];
                CFG_LEASE_TIMEOUT: lease_timeout_reg <= cfg_wdata;
                CFG_HARD_LIMIT:    hard_limit_reg    <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Control: pipeline valids, session state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            active_reg      <= 1'b0;
            lease_reg       <= '0;
            start_reg       <= '0;
            renew_reg       <= '0;
            start_cnt_reg   <= '0;
            stop_cnt_reg    <= '0;
            wd_cnt_reg      <= '0;
            reject_cnt_reg  <= '0;
            cleanup_cnt_reg <= '0;
        end else begin
            if (req_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (rsp_load) begin
                rsp_valid_reg <= s1_valid_reg;
            end
            if (s1_fire) begin
                active_reg      <= active_next;
                lease_reg       <= lease_next;
                start_reg       <= start_next;
                renew_reg       <= renew_next;
                start_cnt_reg   <= start_cnt_next;
                stop_cnt_reg    <= stop_cnt_next;
                wd_cnt_reg      <= wd_cnt_next;
                reject_cnt_reg  <= reject_cnt_next;
                cleanup_cnt_reg <= cleanup_cnt_next;
            end
        end
    end

    // Payload: hold the input item and the result until they move on
    always_ff @(posedge clk)
    begin
        if (req_fire) begin
            s1_item_reg <= req;
        end
        if (s1_fire) begin
            rsp_item_reg <= rsp_next;
        end
    end

`include "tx_tune_lease_watchdog_macros.svh"

    // A release always leaves the session closed
    `TTLW_ASSERT_SAME(a_release_closes, rsp_valid && rsp.release_issued, !rsp.session_active)
    // The start counter moves only with an issued request
    `TTLW_ASSERT_NEXT(a_start_cnt_hold, !(s1_fire && req_iss), $stable(start_cnt_reg))
    // A processed release clears the session state
    `TTLW_ASSERT_NEXT(a_release_clears, s1_fire && rel_iss, !active_reg && lease_reg == '0)

endmodule

`default_nettype wire
